// File: hw/rtl/sscg_pkg.sv
// Package for the stepper step command generator.
// Holds configuration indexes, field widths and the controller/datapath command struct.
// No dependencies.
package sscg_pkg;

	localparam int unsigned CfgWidth = 24;
	localparam int unsigned CfgIdxWidth = 2;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_HIGH_PHASE = 2'd0,
		CFG_OPEN_LOOP  = 2'd1,
		CFG_DIR_SETUP  = 2'd2
	} cfg_idx_t;

	localparam int unsigned QuotWidth = 48;

	typedef struct packed {
		logic load;
		logic plan;
		logic div_start;
		logic shape;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_div;
	} status_t;

endpackage

// File: hw/rtl/stepper_step_command_generator.sv
// Stepper step command generator, one servo period per transaction.
// Steps: load, plan, check, divide if the low half needs it, shape, finish, output.
// One transaction at a time; the next is taken only after the result is accepted.
// Reset (arst_n low): velocity, accumulator and directions clear; registers
// return to high count 20, open loop, direction setup 100.
module stepper_step_command_generator #(
	parameter int unsigned LEN_OVERHEAD = 175,
	parameter int unsigned CLOCK_MHZ = 133
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// velocity_cmd, feedforward_vel, vel_limit, accel_limit, servo_ticks
	input  logic [151:0]  s_tdata,
	// enabled, updated, fifo_drained
	input  logic [2:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// pulse_word, push_step, push_stop, stop_dir, position_delta,
	// velocity_report, pulse_len_us, dir_violation
	output logic [103:0]  m_tdata,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [23:0]   cfg_data
);

	logic [5:0]  hpc_q;
	logic        ol_q;
	logic [23:0] dsm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpc_q <= 6'd20; ol_q <= 1'b1; dsm_q <= 24'd100;
		end else if (cfg_we) begin
			unique case (sscg_pkg::cfg_idx_t'(cfg_idx))
				sscg_pkg::CFG_HIGH_PHASE: hpc_q <= cfg_data[5:0];
				sscg_pkg::CFG_OPEN_LOOP:  ol_q  <= cfg_data[0];
				sscg_pkg::CFG_DIR_SETUP:  dsm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sscg_pkg::cmd_t    cmd;
	sscg_pkg::status_t status;
	logic [30:0] sw;
	logic ps, pst, sd, dv;
	logic signed [15:0] pd;
	logic signed [31:0] vr;
	logic [15:0] sl;

	sscg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .status(status)
	);

	sscg_datapath #(.LEN_OVERHEAD(LEN_OVERHEAD), .CLOCK_MHZ(CLOCK_MHZ)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.high_phase_count(hpc_q), .open_loop(ol_q), .dir_setup_min(dsm_q),
		.velocity_cmd(s_tdata[31:0]), .feedforward_vel(s_tdata[63:32]),
		.vel_limit(s_tdata[94:64]), .accel_limit(s_tdata[126:95]),
		.servo_ticks(s_tdata[150:127]), .enabled(s_tuser[0]), .updated(s_tuser[1]),
		.fifo_drained(s_tuser[2]),
		.pulse_word(sw), .push_step(ps), .push_stop(pst), .stop_dir(sd),
		.position_delta(pd), .velocity_report(vr), .pulse_len_us(sl),
		.dir_violation(dv)
	);

	assign m_tdata = {5'd0, dv, sl, vr, pd, sd, pst, ps, sw};

endmodule

// File: hw/rtl/sscg_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sscg_pkg.
module sscg_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [sscg_pkg::QuotWidth-1:0]     dividend,
	input  logic [31:0]                        divisor,
	output logic                               done,
	output logic [sscg_pkg::QuotWidth-1:0]     quotient
);

	localparam int unsigned W = sscg_pkg::QuotWidth;

	logic [W-1:0] quot_q;
	logic [32:0]  rem_q;
	logic [31:0]  dvs_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic [32:0]  trial;
	logic [33:0]  diff;

	assign trial = {rem_q[31:0], quot_q[W-1]};
	assign diff  = {1'b0, trial} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(W);
				quot_q <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				if (!diff[33]) begin
					rem_q  <= diff[32:0];
					quot_q <= {quot_q[W-2:0], 1'b1};
				end else begin
					rem_q  <= trial;
					quot_q <= {quot_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient = quot_q;

endmodule

// File: hw/rtl/sscg_datapath.sv
// Datapath: velocity limiting, planning, Bresenham accumulator and step word build.
// Depends on sscg_pkg and sscg_divider.
module sscg_datapath #(
	parameter int unsigned LEN_OVERHEAD = 175,
	parameter int unsigned CLOCK_MHZ = 133
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sscg_pkg::cmd_t       cmd,
	output sscg_pkg::status_t    status,
	input  logic [5:0]           high_phase_count,
	input  logic                 open_loop,
	input  logic [23:0]          dir_setup_min,
	input  logic signed [31:0]   velocity_cmd,
	input  logic signed [31:0]   feedforward_vel,
	input  logic [30:0]          vel_limit,
	input  logic signed [31:0]   accel_limit,
	input  logic [23:0]          servo_ticks,
	input  logic                 enabled,
	input  logic                 updated,
	input  logic                 fifo_drained,
	output logic [30:0]          pulse_word,
	output logic                 push_step,
	output logic                 push_stop,
	output logic                 stop_dir,
	output logic signed [15:0]   position_delta,
	output logic signed [31:0]   velocity_report,
	output logic [15:0]          pulse_len_us
	,output logic                dir_violation
);

	localparam int unsigned W = sscg_pkg::QuotWidth;
	localparam int unsigned LenShift = 25 + $clog2(CLOCK_MHZ);
	localparam logic [26:0] LenRecip =
		27'(((64'd1 << LenShift) + 64'(CLOCK_MHZ) - 64'd1) / 64'(CLOCK_MHZ));

	logic signed [31:0] prev_vel_q, vcmd_q, ff_q, lim_q;
	logic [30:0]        vmax_q;
	logic [23:0]        period_q;
	logic               en_q, upd_q, fe_q;
	logic [15:0]        acc_q;
	logic               held_dir_q, plan_dir_q, prev_en_q;
	logic [31:0]        pmag_q;
	logic               dir_q, dchg_q, skip_q;
	logic [16:0]        n_q;
	logic [23:0]        low_q;

	// velocity limit
	logic               idle;
	logic signed [31:0] last;
	logic signed [33:0] v0, d, v1, vmx;
	logic signed [31:0] v;
	logic [31:0]        vmag, ffmag;
	logic               has_ff, sub1, flipped, spike;
	logic signed [31:0] plan;
	logic               pdir;

	assign idle = (period_q == 24'd0) || (!upd_q && prev_vel_q == 32'sd0);

	always_comb begin
		last = (en_q != prev_en_q && en_q && prev_vel_q == 32'sd0) ? vcmd_q : prev_vel_q;
		v0 = 34'(vcmd_q);
		d  = v0 - 34'(last);
		v1 = v0;
		if (lim_q > 32'sd0) begin
			if (d > 34'(lim_q)) v1 = 34'(last) + 34'(lim_q);
			else if (d < -34'(lim_q)) v1 = 34'(last) - 34'(lim_q);
		end
		vmx = $signed({3'b0, vmax_q});
		if (v1 > vmx) v1 = vmx;
		if (v1 < -vmx) v1 = -vmx;
		v = v1[31:0];
		vmag  = v[31] ? 32'(-v) : 32'(v);
		ffmag = ff_q[31] ? 32'(-ff_q) : 32'(ff_q);
		has_ff = ffmag != 0 && vmag != 0;
		sub1 = vmag <= 32'd65536;
		flipped = (ff_q > 32'sd0) ? v[31] : (v > 32'sd0);
		spike = ffmag <= 32'd131072 && flipped;
		plan = (has_ff && (sub1 || spike)) ? ff_q : v;
		pdir = plan > 32'sd0;
	end

	logic [32:0] acc_sum;
	logic [15:0] acc_base;
	logic [31:0] pmag_c;
	assign pmag_c   = plan[31] ? 32'(-plan) : 32'(plan);
	assign acc_base = (plan != 32'sd0 && pdir != plan_dir_q) ? 16'd0 : acc_q;
	assign acc_sum  = {17'd0, acc_base} + {1'b0, pmag_c};

	// low half
	logic          div_done;
	logic [W-1:0]  quot;
	logic [W-1:0]  dividend;
	assign dividend = W'({period_q, 15'd0});

	sscg_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dividend), .divisor(pmag_q), .done(div_done), .quotient(quot)
	);

	assign status.div_done = div_done;
	assign status.need_div = !skip_q && fe_q && pmag_q >= 32'd65536;

	logic               fast;
	logic signed [49:0] low_raw;
	logic [23:0]        low;
	logic [24:0]        len_num;
	logic [15:0]        len_us;
	logic signed [15:0] delta;

	always_comb begin
		fast = pmag_q >= 32'd65536;
		if (fast) low_raw = $signed({2'b0, quot}) - 50'(LEN_OVERHEAD);
		else if (n_q != 17'd0) low_raw = 50'(period_q[23:2]) - 50'(LEN_OVERHEAD);
		else low_raw = '0;
		if (low_raw < 0) low = '0;
		else low = low_raw[23:0];
		if (!open_loop) delta = '0;
		else if (dir_q) delta = (n_q > 17'd32767) ? 16'sd32767 : $signed(n_q[15:0]);
		else delta = -$signed(n_q[15:0]);
	end

	// scale by the reciprocal of the clock rate, exact for any 25-bit numerator
	logic [51:0] len_prod;
	assign len_num  = 25'(low_q) + 25'(LEN_OVERHEAD);
	assign len_prod = 52'(len_num) * 52'(LenRecip);
	assign len_us   = len_prod[LenShift +: 16];

	logic commit;
	logic fin_dir;
	assign commit  = !skip_q && fe_q;
	assign fin_dir = (commit && low_q != 24'd0) ? dir_q : held_dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_vel_q <= '0; acc_q <= '0; held_dir_q <= 1'b0;
			plan_dir_q <= 1'b0; prev_en_q <= 1'b0; low_q <= '0;
			pulse_word <= '0; push_step <= 1'b0; push_stop <= 1'b0; stop_dir <= 1'b0;
			position_delta <= '0; velocity_report <= '0; pulse_len_us <= '0;
			dir_violation <= 1'b0; skip_q <= 1'b1;
		end else begin
			if (cmd.load) begin
				vcmd_q <= velocity_cmd; ff_q <= feedforward_vel; vmax_q <= vel_limit;
				lim_q <= accel_limit; period_q <= servo_ticks; en_q <= enabled;
				upd_q <= updated; fe_q <= fifo_drained;
			end
			if (cmd.plan) begin
				if (idle) begin
					skip_q <= 1'b1;
				end else begin
					prev_en_q  <= en_q;
					prev_vel_q <= v;
					skip_q <= !en_q && v == 32'sd0;
					if (en_q || v != 32'sd0) begin
						if (plan != 32'sd0) plan_dir_q <= pdir;
						acc_q <= acc_sum[15:0];
						n_q   <= acc_sum[32:16];
						pmag_q <= pmag_c;
						dir_q  <= pdir;
						dchg_q <= plan != 32'sd0 && pdir != plan_dir_q;
					end
				end
			end
			if (cmd.shape) begin
				low_q <= low;
			end
			if (cmd.finish) begin
				pulse_word <= commit ? {high_phase_count, low_q, fin_dir} : '0;
				push_step <= commit;
				push_stop <= skip_q ? fe_q : (fe_q && !fast && n_q != 17'd0);
				stop_dir <= fin_dir;
				position_delta <= skip_q ? 16'sd0 : delta;
				velocity_report <= skip_q ? 32'sd0 : ff_q;
				pulse_len_us <= (commit && low_q != 24'd0) ? len_us : 16'd0;
				dir_violation <= commit && dchg_q && low_q != 24'd0 &&
					low_q < dir_setup_min;
				if (commit && low_q != 24'd0) held_dir_q <= dir_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_acc_zero_on_skip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && skip_q |=> !push_step) else $error("step pushed on skipped item");
	a_viol_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		dir_violation |-> push_step) else $error("violation without step");
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_len_us != 16'd0 |-> push_step) else $error("length without step");
`endif

endmodule

// File: hw/rtl/sscg_ctrl.sv
// Controller: sequences load, plan, divide, shape and finish for one transaction.
// Depends on sscg_pkg.
module sscg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output sscg_pkg::cmd_t    cmd,
	input  sscg_pkg::status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PLAN, ST_CHECK, ST_DIV, ST_LOW, ST_FIN, ST_OUT
	} state_t;
	state_t state_q;

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		cmd = '0;
		cmd.load = s_tvalid && s_tready;
		cmd.plan = state_q == ST_PLAN;
		cmd.div_start = state_q == ST_CHECK && status.need_div;
		cmd.shape = state_q == ST_LOW;
		cmd.finish = state_q == ST_FIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_PLAN;
				ST_PLAN: state_q <= ST_CHECK;
				ST_CHECK: state_q <= status.need_div ? ST_DIV : ST_LOW;
				ST_DIV: if (status.div_done) state_q <= ST_LOW;
				ST_LOW: state_q <= ST_FIN;
				ST_FIN: begin
					state_q  <= ST_OUT;
					m_tvalid <= 1'b1;
				end
				ST_OUT: if (m_tready) begin
					m_tvalid <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_q == ST_OUT) else $error("valid outside output state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accept while result held");
	a_div_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == ST_DIV) else $error("divide not entered");
`endif

endmodule
